/* src/pvrg_pkg.sv */
package pvrg_pkg;

	localparam int DIR_BITS     = 20;
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 25;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INV_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INV_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PERSP_SCALE = 3'd3;

	localparam logic MODE_EQUIRECT = 1'b0;
	localparam logic MODE_PERSP    = 1'b1;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef logic signed [CW-1:0] cordic_word_t;

	localparam cordic_word_t ATAN_Q30 [CORDIC_STEPS] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
		34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
		34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
		34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
		34'sd1024, 34'sd512, 34'sd256, 34'sd128
	};

endpackage

/* src/pixel_view_ray_generator_unit.sv */
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------
// pixel in | start, busy         | pix_x, pix_y
// config   | cfg_valid, cfg_ready| cfg_index, cfg_data
// result   | done (strobe)       | dir_x, dir_y, dir_z
//
// one pixel per cycle; from accept to done: three setup stages
// (multiplies, phases, angle scaling), 24 cordic stages, quadrant fix-up,
// product and rounding stages. busy and cfg_ready are always low/high.
// arst_n clears the valid bits and the configuration registers to their reset values.
// nothing stalls: the result strobe lasts one cycle and is not held.
module pixel_view_ray_generator_unit #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [COORD_BITS-1:0] pix_x,
	input  logic [COORD_BITS-1:0] pix_y,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pvrg_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pvrg_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic done,
	output logic signed [pvrg_pkg::DIR_BITS-1:0] dir_x,
	output logic signed [pvrg_pkg::DIR_BITS-1:0] dir_y,
	output logic signed [pvrg_pkg::DIR_BITS-1:0] dir_z
);

	localparam int PW  = COORD_BITS + 25;
	localparam int PPW = PW + 22;
	localparam int CW  = pvrg_pkg::CW;
	localparam int NS  = pvrg_pkg::CORDIC_STEPS;
	localparam int MW  = 2 * CW;
	localparam int DB  = pvrg_pkg::DIR_BITS;
	localparam logic signed [DB-1:0] ZNEG = (FRAC_BITS >= DB - 1) ?
		{1'b1, {(DB-1){1'b0}}} : DB'(-(64'sd1 <<< FRAC_BITS));
	localparam logic signed [PPW-1:0] PMAX = PPW'((64'sd1 <<< (DB-1)) - 1);
	localparam logic signed [PPW-1:0] PMIN = -PMAX - 1;
	localparam logic signed [MW-1:0]  MMAX = MW'((64'sd1 <<< (DB-1)) - 1);
	localparam logic signed [MW-1:0]  MMIN = -MMAX - 1;
	localparam logic signed [CW-1:0]  CMAX = CW'((64'sd1 <<< (DB-1)) - 1);
	localparam logic signed [CW-1:0]  CMIN = -CMAX - 1;

	// configuration registers
	logic mode_q;
	logic [24:0] inv_width_q, inv_height_q;
	logic [19:0] persp_scale_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pvrg_pkg::MODE_EQUIRECT;
			inv_width_q <= 25'd65536;
			inv_height_q <= 25'd65536;
			persp_scale_q <= 20'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pvrg_pkg::CFG_MODE:        mode_q <= cfg_data[0];
				pvrg_pkg::CFG_INV_WIDTH:   inv_width_q <= cfg_data[24:0];
				pvrg_pkg::CFG_INV_HEIGHT:  inv_height_q <= cfg_data[24:0];
				pvrg_pkg::CFG_PERSP_SCALE: persp_scale_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// stage 1: coordinate times reciprocal
	logic v_s1, mode_s1;
	logic [PW-1:0] p_s1, q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_q;
		p_s1 <= PW'(pix_x) * PW'(inv_width_q);
		q_s1 <= PW'(pix_y) * PW'(inv_height_q);
	end

	// stage 2: phases of the pixel centre, perspective offsets
	logic v_s2, mode_s2;
	logic [31:0] th_s2, ph_s2;
	logic signed [PW:0] ux_s2, uy_s2;
	logic [PW:0] sumt, sumq;

	assign sumt = {p_s1, 1'b0} + (PW+1)'(inv_width_q);
	assign sumq = {q_s1, 1'b0} + (PW+1)'(inv_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		th_s2 <= {sumt[24:0], 7'b0} - 32'h8000_0000;
		ph_s2 <= {sumq[25:0], 6'b0} - 32'h4000_0000;
		ux_s2 <= signed'({1'b0, p_s1}) - (PW+1)'(1 << 23);
		uy_s2 <= signed'({1'b0, q_s1}) - (PW+1)'(1 << 23);
	end

	// stage 3: residual angle in radians, perspective products
	logic [60:0] mt, mp;
	logic signed [PPW-1:0] prx_s3, pry_s3;

	assign mt = 61'(th_s2[29:0]) * 61'(pvrg_pkg::HALF_PI_Q30);
	assign mp = 61'(ph_s2[29:0]) * 61'(pvrg_pkg::HALF_PI_Q30);

	logic signed [CW-1:0] tx_s [0:NS];
	logic signed [CW-1:0] ty_s [0:NS];
	logic signed [CW-1:0] tz_s [0:NS];
	logic signed [CW-1:0] px_s [0:NS];
	logic signed [CW-1:0] py_s [0:NS];
	logic signed [CW-1:0] pz_s [0:NS];
	logic [1:0] qt_s [0:NS];
	logic [1:0] qp_s [0:NS];
	logic v_s [0:NS+2];
	logic m_s [0:NS+2];
	logic signed [DB-1:0] pdx_s [1:NS+2];
	logic signed [DB-1:0] pdy_s [1:NS+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		m_s[0] <= mode_s2;
		tz_s[0] <= signed'(CW'((mt + 61'(1 << 29)) >> 30));
		pz_s[0] <= signed'(CW'((mp + 61'(1 << 29)) >> 30));
		tx_s[0] <= pvrg_pkg::CORDIC_GAIN_Q30;
		ty_s[0] <= '0;
		px_s[0] <= pvrg_pkg::CORDIC_GAIN_Q30;
		py_s[0] <= '0;
		qt_s[0] <= th_s2[31:30];
		qp_s[0] <= ph_s2[31:30];
		prx_s3 <= PPW'(ux_s2) * signed'(PPW'(persp_scale_q));
		pry_s3 <= PPW'(uy_s2) * signed'(PPW'(persp_scale_q));
	end

	// stage 4: perspective rounding and saturation
	logic signed [PPW-1:0] rpx, rpy;

	assign rpx = (prx_s3 + (PPW'(1) <<< (37 - FRAC_BITS))) >>> (38 - FRAC_BITS);
	assign rpy = (pry_s3 + (PPW'(1) <<< (37 - FRAC_BITS))) >>> (38 - FRAC_BITS);

	always_ff @(posedge clk) begin
		pdx_s[1] <= (rpx > PMAX) ? PMAX[DB-1:0] : (rpx < PMIN) ? PMIN[DB-1:0] : rpx[DB-1:0];
		pdy_s[1] <= (rpy > PMAX) ? PMAX[DB-1:0] : (rpy < PMIN) ? PMIN[DB-1:0] : rpy[DB-1:0];
	end

	genvar gi;
	generate
		for (gi = 0; gi < NS; gi++) begin : g_cordic
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[gi+1] <= 1'b0;
				else v_s[gi+1] <= v_s[gi];
			end

			always_ff @(posedge clk) begin
				m_s[gi+1] <= m_s[gi];
				qt_s[gi+1] <= qt_s[gi];
				qp_s[gi+1] <= qp_s[gi];
				if (tz_s[gi] >= 0) begin
					tx_s[gi+1] <= tx_s[gi] - (ty_s[gi] >>> gi);
					ty_s[gi+1] <= ty_s[gi] + (tx_s[gi] >>> gi);
					tz_s[gi+1] <= tz_s[gi] - pvrg_pkg::ATAN_Q30[gi];
				end else begin
					tx_s[gi+1] <= tx_s[gi] + (ty_s[gi] >>> gi);
					ty_s[gi+1] <= ty_s[gi] - (tx_s[gi] >>> gi);
					tz_s[gi+1] <= tz_s[gi] + pvrg_pkg::ATAN_Q30[gi];
				end
				if (pz_s[gi] >= 0) begin
					px_s[gi+1] <= px_s[gi] - (py_s[gi] >>> gi);
					py_s[gi+1] <= py_s[gi] + (px_s[gi] >>> gi);
					pz_s[gi+1] <= pz_s[gi] - pvrg_pkg::ATAN_Q30[gi];
				end else begin
					px_s[gi+1] <= px_s[gi] + (py_s[gi] >>> gi);
					py_s[gi+1] <= py_s[gi] - (px_s[gi] >>> gi);
					pz_s[gi+1] <= pz_s[gi] + pvrg_pkg::ATAN_Q30[gi];
				end
			end
		end

		for (gi = 1; gi < NS + 2; gi++) begin : g_pdelay
			always_ff @(posedge clk) begin
				pdx_s[gi+1] <= pdx_s[gi];
				pdy_s[gi+1] <= pdy_s[gi];
			end
		end

		for (gi = NS; gi < NS + 2; gi++) begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[gi+1] <= 1'b0;
				else v_s[gi+1] <= v_s[gi];
			end

			always_ff @(posedge clk) begin
				m_s[gi+1] <= m_s[gi];
			end
		end
	endgenerate

	// quadrant fix-up
	logic signed [CW-1:0] ct_c, st_c, cp_c, sp_c;
	logic signed [CW-1:0] st_s28, ct_s28, cp_s28, sp_s28;

	always_comb begin
		case (qt_s[NS])
			2'd0: begin ct_c = tx_s[NS]; st_c = ty_s[NS]; end
			2'd1: begin ct_c = -ty_s[NS]; st_c = tx_s[NS]; end
			2'd2: begin ct_c = -tx_s[NS]; st_c = -ty_s[NS]; end
			default: begin ct_c = ty_s[NS]; st_c = -tx_s[NS]; end
		endcase
		case (qp_s[NS])
			2'd0: begin cp_c = px_s[NS]; sp_c = py_s[NS]; end
			2'd1: begin cp_c = -py_s[NS]; sp_c = px_s[NS]; end
			2'd2: begin cp_c = -px_s[NS]; sp_c = -py_s[NS]; end
			default: begin cp_c = py_s[NS]; sp_c = -px_s[NS]; end
		endcase
	end

	always_ff @(posedge clk) begin
		ct_s28 <= ct_c;
		st_s28 <= st_c;
		cp_s28 <= cp_c;
		sp_s28 <= sp_c;
	end

	// products of the trig terms
	logic signed [MW-1:0] mx_s29, mz_s29;
	logic signed [CW-1:0] sp_s29;

	always_ff @(posedge clk) begin
		mx_s29 <= MW'(st_s28) * MW'(cp_s28);
		mz_s29 <= -(MW'(ct_s28) * MW'(cp_s28));
		sp_s29 <= sp_s28;
	end

	// rounding, saturation and mode select
	logic signed [MW-1:0] rmx, rmz;
	logic signed [CW-1:0] rsp;
	logic signed [DB-1:0] ex, ey, ez;
	logic mode_out_q;

	assign rmx = (mx_s29 + (MW'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
	assign rmz = (mz_s29 + (MW'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
	assign rsp = (sp_s29 + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

	always_comb begin
		ex = (rmx > MMAX) ? MMAX[DB-1:0] : (rmx < MMIN) ? MMIN[DB-1:0] : rmx[DB-1:0];
		ez = (rmz > MMAX) ? MMAX[DB-1:0] : (rmz < MMIN) ? MMIN[DB-1:0] : rmz[DB-1:0];
		ey = (rsp > CMAX) ? CMAX[DB-1:0] : (rsp < CMIN) ? CMIN[DB-1:0] : rsp[DB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s[NS+2];
	end

	always_ff @(posedge clk) begin
		mode_out_q <= m_s[NS+2];
		if (m_s[NS+2] == pvrg_pkg::MODE_PERSP) begin
			dir_x <= pdx_s[NS+2];
			dir_y <= pdy_s[NS+2];
			dir_z <= ZNEG;
		end else begin
			dir_x <= ex;
			dir_y <= ey;
			dir_z <= ez;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##30 done)
		else $error("result strobe missing after pipeline latency");

	a_persp_z: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_out_q == pvrg_pkg::MODE_PERSP) |-> dir_z == ZNEG)
		else $error("perspective z word is not minus one");

	a_cfg_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == pvrg_pkg::CFG_MODE)
		|=> mode_q == $past(cfg_data[0]))
		else $error("projection mode write lost");

endmodule

/* sim/tb_pixel_view_ray_generator_unit.sv */
`timescale 1ns / 1ps

module tb_pixel_view_ray_generator_unit;

	localparam int CB = 12;
	localparam int FB = 14;
	localparam int LATENCY = 30;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [pvrg_pkg::DIR_BITS-1:0] dx;
		logic signed [pvrg_pkg::DIR_BITS-1:0] dy;
		logic signed [pvrg_pkg::DIR_BITS-1:0] dz;
	} ray_dir_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [CB-1:0] pix_x, pix_y;
	logic [pvrg_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [pvrg_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic signed [pvrg_pkg::DIR_BITS-1:0] dir_x, dir_y, dir_z;

	pixel_view_ray_generator_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pix_x(pix_x), .pix_y(pix_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
	);

	// shadow copy of the registers
	logic        mode_q;
	logic [24:0] inv_w_q, inv_h_q;
	logic [19:0] scale_q;

	ray_dir_t expected_dirs[$];
	int errors = 0;
	int words_sent = 0, words_checked = 0;
	int idle_pct = 0;
	longint cycles = 0;
	longint cordic_atan[pvrg_pkg::CORDIC_STEPS];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [pvrg_pkg::DIR_BITS-1:0] clip_dir(longint v);
		if (v > 524287) return 20'sd524287;
		if (v < -524288) return 20'sh80000;
		return v[pvrg_pkg::DIR_BITS-1:0];
	endfunction

	task automatic phase_sincos(input logic [31:0] ph, output longint c, output longint s);
		longint x, y, z, dx, dy;
		longint unsigned r;
		r = 64'(ph[29:0]);
		z = longint'((r * 64'd1686629713 + (64'd1 << 29)) >> 30);
		x = 64'sd652032874;
		y = 64'sd0;
		for (int i = 0; i < pvrg_pkg::CORDIC_STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= cordic_atan[i];
			end else begin
				x += dx; y -= dy; z += cordic_atan[i];
			end
		end
		case (ph[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_ray(input logic [CB-1:0] px, input logic [CB-1:0] py,
			output ray_dir_t d);
		logic [31:0] th, ph;
		longint ct, st, cp, sp, ux, uy;
		longint unsigned tmp;
		if (mode_q == pvrg_pkg::MODE_EQUIRECT) begin
			tmp = ((2 * longint'(px) + 1) * longint'(inv_w_q)) << 7;
			th = tmp[31:0] - 32'h8000_0000;
			tmp = ((2 * longint'(py) + 1) * longint'(inv_h_q)) << 6;
			ph = tmp[31:0] - 32'h4000_0000;
			phase_sincos(th, ct, st);
			phase_sincos(ph, cp, sp);
			d.dx = clip_dir(rnd_shift(st * cp, 60 - FB));
			d.dy = clip_dir(rnd_shift(sp, 30 - FB));
			d.dz = clip_dir(rnd_shift(-(ct * cp), 60 - FB));
		end else begin
			ux = longint'(px) * longint'(inv_w_q) - (64'sd1 <<< 23);
			uy = longint'(py) * longint'(inv_h_q) - (64'sd1 <<< 23);
			d.dx = clip_dir(rnd_shift(ux * longint'(scale_q), 38 - FB));
			d.dy = clip_dir(rnd_shift(uy * longint'(scale_q), 38 - FB));
			d.dz = clip_dir(-(64'sd1 <<< FB));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		ray_dir_t e;
		if (arst_n && done) begin
			if (expected_dirs.size() == 0) begin
				$display("%0t: unexpected result word %0d %0d %0d", $time,
					dir_x, dir_y, dir_z);
				errors++;
			end else begin
				e = expected_dirs.pop_front();
				words_checked++;
				if (dir_x !== e.dx) begin
					$display("%0t: dir_x expected %0d actual %0d", $time, e.dx, dir_x);
					errors++;
				end
				if (dir_y !== e.dy) begin
					$display("%0t: dir_y expected %0d actual %0d", $time, e.dy, dir_y);
					errors++;
				end
				if (dir_z !== e.dz) begin
					$display("%0t: dir_z expected %0d actual %0d", $time, e.dz, dir_z);
					errors++;
				end
			end
		end
	end

	// start stays high after the word so that the next one can follow at once
	task automatic send_pixel(input logic [CB-1:0] px, input logic [CB-1:0] py);
		ray_dir_t d;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		pix_x <= px;
		pix_y <= py;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_ray(px, py, d);
		expected_dirs.push_back(d);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 0;
		while (expected_dirs.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [pvrg_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [24:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pvrg_pkg::CFG_MODE: mode_q = val[0];
			pvrg_pkg::CFG_INV_WIDTH: inv_w_q = val;
			pvrg_pkg::CFG_INV_HEIGHT: inv_h_q = val;
			pvrg_pkg::CFG_PERSP_SCALE: scale_q = val[19:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic set_view(input logic m, input logic [24:0] iw, input logic [24:0] ih,
			input logic [19:0] sc);
		drain();
		write_reg(pvrg_pkg::CFG_MODE, 25'(m));
		write_reg(pvrg_pkg::CFG_INV_WIDTH, iw);
		write_reg(pvrg_pkg::CFG_INV_HEIGHT, ih);
		write_reg(pvrg_pkg::CFG_PERSP_SCALE, 25'(sc));
	endtask

	task automatic test_directed;
		logic [CB-1:0] corners[4] = '{12'd0, 12'd1, 12'd2048, 12'd4095};
		foreach (corners[i]) foreach (corners[j]) send_pixel(corners[i], corners[j]);
		// out-of-range index must leave the registers alone
		drain();
		write_reg(3'd5, 25'h1FFFFFF);
		write_reg(3'd7, 25'h0);
		send_pixel(12'd100, 12'd200);
		send_pixel(12'hAAA, 12'h555);
	endtask

	task automatic test_extremes;
		set_view(pvrg_pkg::MODE_PERSP, 25'd16777216, 25'd16777216, 20'hFFFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd4094);
		set_view(pvrg_pkg::MODE_PERSP, 25'd0, 25'd0, 20'd0);
		send_pixel(12'd4095, 12'd0);
		set_view(pvrg_pkg::MODE_EQUIRECT, 25'd16777216, 25'd16777216, 20'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		set_view(pvrg_pkg::MODE_EQUIRECT, 25'h1FFFFFF, 25'h1FFFFFF, 20'd32768);
		send_pixel(12'd4095, 12'd3);
	endtask

	task automatic random_phase(input int pct, input int n);
		logic [24:0] iw, ih;
		idle_pct = pct;
		for (int k = 0; k < n; k++) begin
			if (k % 100 == 0) begin
				iw = $urandom_range(3) == 0 ? 25'($urandom) : 25'($urandom_range(16777216, 4096));
				ih = $urandom_range(3) == 0 ? 25'($urandom) : 25'($urandom_range(16777216, 4096));
				set_view(1'($urandom_range(1)), iw, ih, 20'($urandom));
			end
			send_pixel(12'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		foreach (cordic_atan[i]) cordic_atan[i] = longint'(pvrg_pkg::ATAN_Q30[i]);
		mode_q = pvrg_pkg::MODE_EQUIRECT;
		inv_w_q = 25'd65536;
		inv_h_q = 25'd65536;
		scale_q = 20'd32768;
		arst_n = 0;
		start = 0;
		pix_x = '0;
		pix_y = '0;
		cfg_valid = 0;
		cfg_index = pvrg_pkg::CFG_MODE;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_extremes();
		random_phase(0, 400);
		random_phase(52, 400);
		random_phase(28, 400);
		random_phase(0, 400);
		drain();
		$display("%0d pixels sent, %0d rays checked, both projections", words_sent, words_checked);
		$display("reciprocal, scale and idle-gap settings swept, extremes included");
		if (errors == 0 && expected_dirs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
src/pvrg_pkg.sv
src/pixel_view_ray_generator_unit.sv
sim/tb_pixel_view_ray_generator_unit.sv
